[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define SMX_ASSERT(lbl, clk_i, rst_ni, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define SMX_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hw/rtl/smx_pkg.sv]
`timescale 1ns / 1ps

package smx_pkg;

  localparam int WORD_W      = 32;
  localparam int PAYLOAD_W   = 30;
  localparam int OUT_COUNT_W = 9;
  localparam int ERR_W       = 2;
  localparam int OUT_TDATA_W = 48;

  localparam logic [PAYLOAD_W-1:0] PRIM_HALT = 30'd0;
  localparam logic [PAYLOAD_W-1:0] PRIM_ADD  = 30'd1;
  localparam logic [PAYLOAD_W-1:0] PRIM_SUB  = 30'd2;
  localparam logic [PAYLOAD_W-1:0] PRIM_MUL  = 30'd3;
  localparam logic [PAYLOAD_W-1:0] PRIM_DIV  = 30'd4;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_DIVZ  = 2'd3;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_HALT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t             op;
    logic [PAYLOAD_W-1:0] data;
  } op_item_t;

endpackage

[hw/rtl/smx_front.sv]
`timescale 1ns / 1ps

module smx_front
  import smx_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [WORD_W-1:0] in_tdata,
  output logic              head_valid,
  output op_item_t          head,
  input  logic              pop
);

  op_item_t    ent_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  op_item_t    cls;

  // Decode header and primitive code.
  always_comb begin
    cls.data = in_tdata[PAYLOAD_W-1:0];
    if (!in_tdata[WORD_W-2]) begin
      cls.op = OP_PUSH;
    end else begin
      case (in_tdata[PAYLOAD_W-1:0])
        PRIM_HALT: cls.op = OP_HALT;
        PRIM_ADD:  cls.op = OP_ADD;
        PRIM_SUB:  cls.op = OP_SUB;
        PRIM_MUL:  cls.op = OP_MUL;
        PRIM_DIV:  cls.op = OP_DIV;
        default:   cls.op = OP_NOP;
      endcase
    end
  end

  assign in_tready  = (cnt_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign head_valid = (cnt_r != 2'd0);
  assign head       = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[hw/rtl/smx_div.sv]
`timescale 1ns / 1ps

module smx_div
  import smx_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] quotient
);

  logic              busy_r;
  logic              done_r;
  logic [4:0]        step_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] quo_r;
  logic [WORD_W-1:0] div_r;
  logic              neg_r;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;

  // One restoring step per cycle on magnitudes.
  assign shifted = {rem_r, quo_r[WORD_W-1]};
  assign diff    = shifted - {1'b0, div_r};

  assign done     = done_r;
  assign quotient = neg_r ? (WORD_W'(0) - quo_r) : quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 5'd0;
      end else if (busy_r) begin
        if (step_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
      div_r <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
      neg_r <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
    end else if (busy_r) begin
      if (!diff[WORD_W]) begin
        rem_r <= diff[WORD_W-1:0];
        quo_r <= {quo_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[WORD_W-1:0];
        quo_r <= {quo_r[WORD_W-2:0], 1'b0};
      end
    end
  end

endmodule

[hw/rtl/smx_back.sv]
`timescale 1ns / 1ps

module smx_back
  import smx_pkg::*;
#(
  parameter int STACK_DEPTH = 256
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  op_item_t               head,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV
  } state_t;

  state_t                  state_r, state_nxt;
  op_kind_t                op_r, op_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [WORD_W-1:0]       top_r, top_nxt;
  logic                    halted_r, halted_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]  out_data_r, out_data_nxt;

  // Entries below the top; the top itself lives in top_r.
  logic [WORD_W-1:0]       mem [STACK_DEPTH];
  logic [WORD_W-1:0]       rd_data_r;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           rd_addr;
  logic                    mem_we;

  logic                    div_start;
  logic                    div_done;
  logic [WORD_W-1:0]       div_quo;

  logic                    out_free;
  logic                    emit;
  logic [ERR_W-1:0]        err;
  logic [WORD_W-1:0]       top_shown;

  assign wr_addr  = AW'(count_r - CW'(1));
  assign rd_addr  = AW'(count_r - CW'(2));
  assign out_free = !out_valid_r || out_tready;

  smx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data_r),
    .divisor  (top_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    count_nxt  = count_r;
    top_nxt    = top_r;
    halted_nxt = halted_r;
    emit       = 1'b0;
    err        = ERR_NONE;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    pop        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (head_valid && out_free) begin
          pop = 1'b1;
          if (halted_r) begin
            emit = 1'b1;
          end else begin
            case (head.op)
              OP_PUSH: begin
                emit = 1'b1;
                if (count_r == CW'(STACK_DEPTH)) begin
                  err = ERR_OVER;
                end else begin
                  mem_we    = (count_r != '0);
                  top_nxt   = WORD_W'(head.data);
                  count_nxt = count_r + CW'(1);
                end
              end
              OP_HALT: begin
                emit       = 1'b1;
                halted_nxt = 1'b1;
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (count_r < CW'(2)) begin
                  emit = 1'b1;
                  err  = ERR_UNDER;
                end else if (head.op == OP_DIV && top_r == '0) begin
                  emit = 1'b1;
                  err  = ERR_DIVZ;
                end else begin
                  op_nxt    = head.op;
                  state_nxt = S_READ;
                end
              end
              default: begin
                emit = 1'b1;
              end
            endcase
          end
        end
      end
      S_READ: begin
        case (op_r)
          OP_ADD: begin
            top_nxt   = rd_data_r + top_r;
            count_nxt = count_r - CW'(1);
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
          OP_SUB: begin
            top_nxt   = rd_data_r - top_r;
            count_nxt = count_r - CW'(1);
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
          OP_MUL: begin
            top_nxt   = rd_data_r * top_r;
            count_nxt = count_r - CW'(1);
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end
          OP_DIV: begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          top_nxt   = div_quo;
          count_nxt = count_r - CW'(1);
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    top_shown    = (count_nxt != '0) ? top_nxt : '0;
    out_data_nxt = {(OUT_TDATA_W - WORD_W - OUT_COUNT_W - 1 - ERR_W)'(0), err, halted_nxt,
                    OUT_COUNT_W'(count_nxt), top_shown};
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r  <= op_nxt;
    top_r <= top_nxt;
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= top_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hw/rtl/stack_machine_executor_unit.sv]
`timescale 1ns / 1ps
// Push, halt, no-op and error items give their result straight from the idle state;
//   add, sub and mul first read the second entry; divide runs a 32-step radix-2 divider.
// Throughput: one push per cycle while the output is not stalled; add/sub/mul wait on the
//   stack second-entry memory read, and a divide holds off the next item until it is done.
// Reset (rst_n low, synchronous): stack empty, machine running, queue and output empty.

module stack_machine_executor_unit
  import smx_pkg::*;
#(
  parameter int STACK_DEPTH = 256
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [WORD_W-1:0]      in_tdata,   // [31:0] instruction_word
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [31:0] top_value, [40:32] stack_count,
                                             // [41] halted, [43:42] error_code, [47:44] zero
);

  // Queue head from the front part to the back part.
  logic     head_valid;
  op_item_t head;
  logic     pop;

  // Front: accept each item, decode header and primitive, hold it in a
  // two-entry queue so input acceptance waits on the stack unit only when the queue is full.
  smx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Back: keep the top entry in a register and the rest in a memory.
  // Push writes the old top to memory and loads the new one; arithmetic
  // reads the second entry, combines it with the top and drops one entry.
  // Drop every item after a halt but still report the unchanged stack.
  // Hold a finished result in the output register while taking the next
  // queued item as soon as that register is free or being drained.
  smx_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[hw/rtl/smx_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smx_checker
  import smx_pkg::*;
#(
  parameter int STACK_DEPTH = 256
)
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic             stalled;
  logic             halt_fire;
  logic             halt_kept;
  logic             halt_shown;
  logic             empty_shown;
  logic             top_zero;
  logic [ERR_W-1:0] out_err;

  assign stalled     = out_tvalid && !out_tready;
  assign halt_fire   = out_tvalid && out_tready && out_tdata[41];
  assign halt_kept   = !out_tvalid || out_tdata[41];
  assign halt_shown  = out_tvalid && out_tdata[41];
  assign out_err     = out_tdata[43:42];
  // A count field of zero only means empty while the depth fits in it.
  assign empty_shown = (STACK_DEPTH < 512) && out_tvalid && (out_tdata[40:32] == 9'd0);
  assign top_zero    = (out_tdata[31:0] == 32'd0);

  `SMX_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_tvalid, "output valid after reset")
  `SMX_ASSERT(a_out_hold, clk, rst_n, stalled |=> out_tvalid && $stable(out_tdata), "item changed")
  `SMX_ASSERT(a_halt_sticky, clk, rst_n, halt_fire |=> halt_kept, "halted flag cleared")
  `SMX_ASSERT(a_halt_no_err, clk, rst_n, halt_shown |-> out_err == ERR_NONE, "error while halted")
  `SMX_ASSERT(a_empty_top_zero, clk, rst_n, empty_shown |-> top_zero, "empty stack top nonzero")

endmodule

bind stack_machine_executor_unit smx_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_smx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import smx_pkg::*;

  localparam int DEPTH           = 256;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 64;    // longer than the divide latency
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_PRINTED     = 100;
  localparam int RANDOM_PER_PHASE = 150;

  // Instruction header codes, bits 31:30 of the item.
  localparam logic [1:0] HDR_PUSH     = 2'd0;
  localparam logic [1:0] HDR_PRIM     = 2'd1;
  localparam logic [1:0] HDR_PUSH_ALT = 2'd2;
  localparam logic [1:0] HDR_PRIM_ALT = 2'd3;

  localparam logic [PAYLOAD_W-1:0] DATA_MAX = {PAYLOAD_W{1'b1}};

  typedef struct packed {
    logic [WORD_W-1:0]      top;
    logic [OUT_COUNT_W-1:0] count;
    logic                   halted;
    logic [ERR_W-1:0]       err;
  } machine_view_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [WORD_W-1:0]      in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int cycle_count = 0;
  int fail_count  = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;
  int hold_seen  = 0;
  int hold_left  = 0;

  // Predicted machine state, advanced on every accepted item.
  logic [WORD_W-1:0] model_stack [DEPTH];
  int unsigned       model_depth = 0;
  logic              model_halted = 1'b0;
  machine_view_t     expected_views [$];

  stack_machine_executor_unit #(.STACK_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Execute one instruction on the predicted machine and queue the view it yields.
  function automatic void predict_instruction(input logic [WORD_W-1:0] word);
    logic [1:0]           hdr;
    logic [PAYLOAD_W-1:0] data;
    logic [ERR_W-1:0]     err;
    logic [WORD_W-1:0]    lhs, rhs, res, mag_l, mag_r;
    logic [2*WORD_W-1:0]  product;
    machine_view_t        view;
    hdr  = word[WORD_W-1:PAYLOAD_W];
    data = word[PAYLOAD_W-1:0];
    err  = ERR_NONE;
    res  = '0;
    if (!model_halted) begin
      if (hdr == HDR_PUSH || hdr == HDR_PUSH_ALT) begin
        if (model_depth >= DEPTH) begin
          err = ERR_OVER;
        end else begin
          model_stack[model_depth] = {{(WORD_W-PAYLOAD_W){1'b0}}, data};
          model_depth++;
        end
      end else if (data == PRIM_HALT) begin
        model_halted = 1'b1;
      end else if (data == PRIM_ADD || data == PRIM_SUB || data == PRIM_MUL ||
                   data == PRIM_DIV) begin
        if (model_depth < 2) begin
          err = ERR_UNDER;
        end else begin
          lhs = model_stack[model_depth-2];
          rhs = model_stack[model_depth-1];
          case (data)
            PRIM_ADD: res = lhs + rhs;
            PRIM_SUB: res = lhs - rhs;
            PRIM_MUL: begin
              product = lhs * rhs;
              res = product[WORD_W-1:0];
            end
            default: begin
              // Signed divide, truncating toward zero; min / -1 wraps to min.
              if (rhs == '0) begin
                err = ERR_DIVZ;
              end else begin
                mag_l = lhs[WORD_W-1] ? -lhs : lhs;
                mag_r = rhs[WORD_W-1] ? -rhs : rhs;
                res = mag_l / mag_r;
                if (lhs[WORD_W-1] ^ rhs[WORD_W-1]) res = -res;
              end
            end
          endcase
          if (err == ERR_NONE) begin
            model_stack[model_depth-2] = res;
            model_depth--;
          end
        end
      end
    end
    view.top    = (model_depth != 0) ? model_stack[model_depth-1] : '0;
    view.count  = model_depth[OUT_COUNT_W-1:0];
    view.halted = model_halted;
    view.err    = err;
    expected_views.push_back(view);
  endfunction

  // Pick a random instruction; bias toward pushes on a shallow stack so
  // arithmetic mostly finds its operands, with some underflow left in.
  function automatic logic [WORD_W-1:0] random_instruction();
    int unsigned          push_pct;
    logic [1:0]           hdr;
    logic [PAYLOAD_W-1:0] data;
    push_pct = (model_depth < 2) ? 70 : ((model_depth > 200) ? 20 : 50);
    if ($urandom_range(99) < push_pct) begin
      hdr = $urandom_range(1) ? HDR_PUSH_ALT : HDR_PUSH;
      case ($urandom_range(3))
        0:       data = PAYLOAD_W'($urandom_range(3));
        1:       data = DATA_MAX;
        default: data = PAYLOAD_W'($urandom());
      endcase
    end else begin
      hdr = $urandom_range(1) ? HDR_PRIM_ALT : HDR_PRIM;
      case ($urandom_range(9))
        0, 1:    data = PRIM_ADD;
        2, 3:    data = PRIM_SUB;
        4, 5:    data = PRIM_MUL;
        6, 7, 8: data = PRIM_DIV;
        default: data = PAYLOAD_W'($urandom_range(DATA_MAX, 5));   // unknown primitive
      endcase
    end
    return {hdr, data};
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    if (fail_count < MAX_PRINTED)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    fail_count++;
  endtask

  // Offer one item after an optional random gap; hold it until accepted.
  // Leave tvalid high afterwards so back-to-back items never toggle it.
  task automatic send_word(input logic [WORD_W-1:0] word);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom();
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    predict_instruction(word);
  endtask

  // Drop tvalid and wait until every predicted result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_views.size() != 0);
  endtask

  // Receiver: random stalls per phase, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest predicted view.
  always @(posedge clk) begin : check_results
    machine_view_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.top    = out_tdata[31:0];
      got.count  = out_tdata[40:32];
      got.halted = out_tdata[41];
      got.err    = out_tdata[43:42];
      if (expected_views.size() == 0) begin
        report_mismatch("result with nothing expected", got.top, '0);
      end else begin
        want = expected_views.pop_front();
        if (got.top !== want.top) report_mismatch("top_value", got.top, want.top);
        if (got.count !== want.count)
          report_mismatch("stack_count", {23'd0, got.count}, {23'd0, want.count});
        if (got.halted !== want.halted)
          report_mismatch("halted", {31'd0, got.halted}, {31'd0, want.halted});
        if (got.err !== want.err)
          report_mismatch("error_code", {30'd0, got.err}, {30'd0, want.err});
      end
    end
  end

  // Arithmetic on an empty and a one-entry stack, unknown codes, push extremes.
  task automatic test_empty_stack();
    send_word({HDR_PRIM, PRIM_ADD});
    send_word({HDR_PRIM_ALT, PRIM_DIV});
    send_word({HDR_PUSH, 30'd0});
    send_word({HDR_PRIM, PRIM_MUL});
    send_word({HDR_PRIM, 30'd5});
    send_word({HDR_PRIM_ALT, DATA_MAX});
    send_word({HDR_PUSH_ALT, DATA_MAX});
  endtask

  // Every arithmetic primitive, wraparound, divide by zero, signed division
  // with truncation, and the most negative value divided by minus one.
  task automatic test_arithmetic();
    send_word({HDR_PRIM, PRIM_ADD});
    send_word({HDR_PUSH, 30'd0});
    send_word({HDR_PRIM_ALT, PRIM_DIV});      // divide by zero
    send_word({HDR_PRIM_ALT, PRIM_SUB});
    send_word({HDR_PUSH, 30'h2000_0000});
    send_word({HDR_PUSH_ALT, 30'd4});
    send_word({HDR_PRIM, PRIM_MUL});          // builds the most negative value
    send_word({HDR_PUSH, 30'd0});
    send_word({HDR_PUSH, 30'd1});
    send_word({HDR_PRIM, PRIM_SUB});          // minus one
    send_word({HDR_PRIM, PRIM_DIV});          // wraps back to the most negative value
    send_word({HDR_PUSH, 30'd0});
    send_word({HDR_PUSH, 30'd7});
    send_word({HDR_PRIM, PRIM_SUB});          // minus seven
    send_word({HDR_PUSH_ALT, 30'd2});
    send_word({HDR_PRIM_ALT, PRIM_DIV});      // truncates to minus three
    send_word({HDR_PUSH, DATA_MAX});
    send_word({HDR_PRIM_ALT, PRIM_MUL});
    send_word({HDR_PRIM, PRIM_ADD});
    drain_results();
  endtask

  // Fill the stack, push into a full stack, then fold it back down.
  task automatic test_overflow();
    logic [PAYLOAD_W-1:0] op;
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    while (model_depth < DEPTH) send_word({HDR_PUSH, PAYLOAD_W'($urandom())});
    send_word({HDR_PUSH_ALT, DATA_MAX});
    send_word({HDR_PUSH, 30'd0});
    while (model_depth > 4) begin
      case ($urandom_range(2))
        0:       op = PRIM_ADD;
        1:       op = PRIM_SUB;
        default: op = PRIM_MUL;
      endcase
      send_word({$urandom_range(1) ? HDR_PRIM_ALT : HDR_PRIM, op});
    end
    drain_results();
  endtask

  task automatic test_random_mix(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (RANDOM_PER_PHASE) send_word(random_instruction());
    drain_results();
  endtask

  // Hold the receiver off while the sender keeps offering fast items,
  // so the block fills up and stalls its input.
  task automatic test_backpressure();
    logic [PAYLOAD_W-1:0] op;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_token++;
    repeat (40) begin
      send_word({HDR_PUSH, PAYLOAD_W'($urandom())});
      case ($urandom_range(2))
        0:       op = PRIM_ADD;
        1:       op = PRIM_SUB;
        default: op = PRIM_MUL;
      endcase
      send_word({HDR_PRIM, op});
    end
    drain_results();
  endtask

  // Halt, then check that pushes, arithmetic, a second halt and random items are all ignored.
  task automatic test_halt();
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    send_word({HDR_PRIM_ALT, PRIM_HALT});
    send_word({HDR_PUSH, 30'd9});
    send_word({HDR_PRIM, PRIM_ADD});
    send_word({HDR_PRIM, PRIM_HALT});
    send_word({HDR_PRIM_ALT, PRIM_DIV});
    repeat (20) send_word(random_instruction());
    drain_results();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stack();
    test_arithmetic();
    test_overflow();
    test_random_mix(0, 0);
    test_random_mix(67, 0);
    test_random_mix(0, 67);
    test_random_mix(27, 27);
    test_backpressure();
    test_halt();

    // Let any stray result surface before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_views.size() != 0)
      report_mismatch("results never arrived", expected_views.size(), '0);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[stack_machine_executor_unit.f]
+incdir+hw/rtl
hw/rtl/smx_pkg.sv
hw/rtl/smx_front.sv
hw/rtl/smx_div.sv
hw/rtl/smx_back.sv
hw/rtl/stack_machine_executor_unit.sv
hw/rtl/smx_checker.sv
tb/testbench.sv
